/* design/mafh_pkg.sv */
// mafh_pkg: types, codes, lookup tables and reciprocal constants for the
// MPEG audio frame header decoder. No dependencies.
package mafh_pkg;

    // status codes, in check priority order
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SYNC     = 3'd1,
        ST_RSV_VERSION = 3'd2,
        ST_RSV_LAYER   = 3'd3,
        ST_BAD_BITRATE = 3'd4,
        ST_BAD_RATE    = 3'd5
    } t_status;

    // header field codes
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] SYNC_HIGH    = 8'hE0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] LAYER_NONE   = 2'd0;
    localparam logic [1:0] LAYER_ONE    = 2'd1;
    localparam logic [1:0] LAYER_TWO    = 2'd2;
    localparam logic [1:0] MODE_MONO    = 2'b11;
    localparam logic [3:0] BR_FREE      = 4'd0;
    localparam logic [3:0] BR_BAD       = 4'd15;
    localparam logic [1:0] SR_RESERVED  = 2'd3;

    // field widths
    localparam int HZ_W      = 16;
    localparam int KBPS_W    = 9;
    localparam int BYTES_W   = 11;
    localparam int PADADD_W  = 3;
    localparam int K_W       = 18;  // samples per frame * 1000 / 8
    localparam int NUM_W     = 26;  // dividend, at most 55,296,000
    localparam int RECIP_W   = 30;  // ceil(2^42 / hz)
    localparam int RECIP_SHIFT = 42;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - RECIP_SHIFT;
    localparam int LEN_W     = QUOT_W + 1;

    localparam logic [BYTES_W-1:0] FRAME_MAX = 11'd2047;

    // bytes-per-kbit scale for each samples-per-frame value
    localparam int KBIT = 1000;
    localparam logic [K_W-1:0] K_SPF_384  = K_W'(384 * KBIT / 8);
    localparam logic [K_W-1:0] K_SPF_576  = K_W'(576 * KBIT / 8);
    localparam logic [K_W-1:0] K_SPF_1152 = K_W'(1152 * KBIT / 8);

    // reciprocals; floor(n * r >> 42) == floor(n / hz) for n below 2^26
    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] R_11025 = RECIP_W'((RECIP_ONE + 64'd11024) / 64'd11025);
    localparam logic [RECIP_W-1:0] R_12000 = RECIP_W'((RECIP_ONE + 64'd11999) / 64'd12000);
    localparam logic [RECIP_W-1:0] R_8000  = RECIP_W'((RECIP_ONE + 64'd7999) / 64'd8000);
    localparam logic [RECIP_W-1:0] R_22050 = RECIP_W'((RECIP_ONE + 64'd22049) / 64'd22050);
    localparam logic [RECIP_W-1:0] R_24000 = RECIP_W'((RECIP_ONE + 64'd23999) / 64'd24000);
    localparam logic [RECIP_W-1:0] R_16000 = RECIP_W'((RECIP_ONE + 64'd15999) / 64'd16000);
    localparam logic [RECIP_W-1:0] R_44100 = RECIP_W'((RECIP_ONE + 64'd44099) / 64'd44100);
    localparam logic [RECIP_W-1:0] R_48000 = RECIP_W'((RECIP_ONE + 64'd47999) / 64'd48000);
    localparam logic [RECIP_W-1:0] R_32000 = RECIP_W'((RECIP_ONE + 64'd31999) / 64'd32000);

    // bit rate rows: MPEG1 L1, L2, L3, MPEG2/2.5 L1, MPEG2/2.5 L2 and L3
    localparam logic [KBPS_W-1:0] KBPS_TABLE [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // sample rate by version code and rate index
    localparam logic [HZ_W-1:0] HZ_TABLE [0:3][0:3] = '{
        '{16'd11025, 16'd12000, 16'd8000, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:3][0:3] = '{
        '{R_11025, R_12000, R_8000, '0},
        '{'0, '0, '0, '0},
        '{R_22050, R_24000, R_16000, '0},
        '{R_44100, R_48000, R_32000, '0}
    };

    // one classified header
    typedef struct packed {
        t_status               status;
        logic [1:0]            version_code;
        logic [1:0]            layer_number;
        logic [1:0]            channel_count;
        logic [HZ_W-1:0]       hz;
        logic [KBPS_W-1:0]     kbps;
        logic                  pad;
        logic [PADADD_W-1:0]   pad_add;
        logic [K_W-1:0]        spf_k;
        logic [RECIP_W-1:0]    recip;
    } t_item;

    // transaction between front, queue and back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_xfer;

    localparam int QUEUE_DEPTH = 2;

endpackage

/* design/mafh_front.sv */
// mafh_front: accepts header words, checks sync and decodes fields and
// table entries into one registered item. Depends on mafh_pkg.
module mafh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [31:0]    i_header_word,
    input  logic           i_full,
    output logic           busy,
    output mafh_pkg::t_xfer o_push
);
    import mafh_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_push;
    logic  w_accept;

    // header decode and classification
    always_comb begin
        logic [1:0] ver;
        logic [1:0] lay_code;
        logic [1:0] layer;
        logic [3:0] br_idx;
        logic [1:0] sr_idx;
        logic       pad;
        logic [2:0] row;
        logic       sync_ok;
        ver      = i_header_word[20:19];
        lay_code = i_header_word[18:17];
        layer    = (lay_code == 2'd0) ? LAYER_NONE : 2'(3'd4 - {1'b0, lay_code});
        br_idx   = i_header_word[15:12];
        sr_idx   = i_header_word[11:10];
        pad      = i_header_word[9];
        sync_ok  = (i_header_word[31:24] == SYNC_BYTE)
                && ((i_header_word[23:16] & SYNC_HIGH) == SYNC_HIGH);

        n_item = '0;
        n_item.version_code  = ver;
        n_item.layer_number  = layer;
        n_item.channel_count = (i_header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
        n_item.pad           = pad;

        if (!sync_ok) begin
            n_item.status = ST_NO_SYNC;
        end else if (ver == VER_RESERVED) begin
            n_item.status = ST_RSV_VERSION;
        end else if (layer == LAYER_NONE) begin
            n_item.status = ST_RSV_LAYER;
        end else if (br_idx == BR_FREE || br_idx == BR_BAD) begin
            n_item.status = ST_BAD_BITRATE;
        end else if (sr_idx == SR_RESERVED) begin
            n_item.status = ST_BAD_RATE;
        end else begin
            n_item.status = ST_OK;
        end

        // bit rate row
        if (ver == VER_MPEG1) begin
            row = 3'(layer - 2'd1);
        end else begin
            row = (layer == LAYER_ONE) ? 3'd3 : 3'd4;
        end
        if (row > 3'd4) begin
            row = 3'd4;
        end

        // samples per frame scale and padding size
        if (layer == LAYER_ONE) begin
            n_item.spf_k   = K_SPF_384;
            n_item.pad_add = pad ? 3'd4 : 3'd0;
        end else begin
            n_item.spf_k   = (layer == LAYER_TWO || ver == VER_MPEG1) ? K_SPF_1152 : K_SPF_576;
            n_item.pad_add = {2'b00, pad};
        end

        n_item.recip = RECIP_TABLE[ver][sr_idx];
        if (n_item.status == ST_OK) begin
            n_item.hz   = HZ_TABLE[ver][sr_idx];
            n_item.kbps = KBPS_TABLE[row][br_idx];
        end
    end

    assign w_push   = r_valid && !i_full;
    assign busy     = r_valid && i_full;
    assign w_accept = start && !busy;

    // front register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_push.valid = w_push;
    assign o_push.item  = r_item;

endmodule

/* design/mafh_queue.sv */
// mafh_queue: short flop-based queue between front and back.
// Depends on mafh_pkg.
module mafh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mafh_pkg::t_xfer i_push,
    input  logic            i_pop,
    output logic            o_full,
    output mafh_pkg::t_xfer o_head
);
    import mafh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_empty;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_pop = i_pop && !w_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !i_push.valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    assign o_head.valid = !w_empty;
    assign o_head.item  = r_mem[r_rd_ptr];

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(1) && i_pop && !i_push.valid) |=> w_empty)
        else $error("queue not empty after last pop");

endmodule

/* design/mafh_back.sv */
// mafh_back: frame length datapath, dividend multiply, reciprocal multiply,
// padding and saturation, registered result strobe. Depends on mafh_pkg.
module mafh_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mafh_pkg::t_xfer                 i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [1:0]                      o_version_code,
    output logic [1:0]                      o_layer_number,
    output logic [1:0]                      o_channel_count,
    output logic [mafh_pkg::HZ_W-1:0]       o_sample_rate_hz,
    output logic [mafh_pkg::KBPS_W-1:0]     o_bit_rate_kbps,
    output logic                            o_padding_bit,
    output logic [mafh_pkg::BYTES_W-1:0]    o_frame_bytes
);
    import mafh_pkg::*;

    logic                  r_s1_valid;
    t_item                 r_s1_item;
    logic [NUM_W-1:0]      r_s1_num;
    logic                  r_s2_valid;
    t_item                 r_s2_item;
    logic [PROD_W-1:0]     r_s2_prod;
    logic                  r_out_valid;
    t_item                 r_out_item;
    logic [BYTES_W-1:0]    r_out_bytes;

    logic [K_W+KBPS_W-1:0] w_num_full;
    logic [PROD_W-1:0]     w_prod;
    logic [QUOT_W-1:0]     w_quot;
    logic [LEN_W-1:0]      w_len;
    logic [BYTES_W-1:0]    n_bytes;

    // back takes every queued transaction at once
    assign o_pop = i_head.valid;

    // stage 1: dividend = spf * 1000 / 8 * kbps
    assign w_num_full = {{KBPS_W{1'b0}}, i_head.item.spf_k}
                      * {{K_W{1'b0}}, i_head.item.kbps};

    // stage 2: dividend times reciprocal of the sample rate
    assign w_prod = {{RECIP_W{1'b0}}, r_s1_num} * {{NUM_W{1'b0}}, r_s1_item.recip};

    // stage 3: quotient, padding, saturation
    always_comb begin
        w_quot = r_s2_prod[PROD_W-1:RECIP_SHIFT];
        w_len  = {1'b0, w_quot} + LEN_W'(r_s2_item.pad_add);
        if (r_s2_item.status != ST_OK) begin
            n_bytes = '0;
        end else if (w_len > LEN_W'(FRAME_MAX)) begin
            n_bytes = FRAME_MAX;
        end else begin
            n_bytes = w_len[BYTES_W-1:0];
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_head.valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        r_s1_item   <= i_head.item;
        r_s1_num    <= w_num_full[NUM_W-1:0];
        r_s2_item   <= r_s1_item;
        r_s2_prod   <= w_prod;
        r_out_item  <= r_s2_item;
        r_out_bytes <= n_bytes;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_item.status;
    assign o_version_code   = r_out_item.version_code;
    assign o_layer_number   = r_out_item.layer_number;
    assign o_channel_count  = r_out_item.channel_count;
    assign o_sample_rate_hz = r_out_item.hz;
    assign o_bit_rate_kbps  = r_out_item.kbps;
    assign o_padding_bit    = r_out_item.pad;
    assign o_frame_bytes    = r_out_bytes;

    // checks
    a_err_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_frame_bytes == '0 && o_sample_rate_hz == '0))
        else $error("error result carries a length or rate");
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_frame_bytes != '0 && o_bit_rate_kbps != '0))
        else $error("good header gave empty frame");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |=> ##2 o_valid)
        else $error("transaction lost in back pipeline");

endmodule

/* design/mpeg_audio_frame_header_decode.sv */
// mpeg_audio_frame_header_decode: top level of the MPEG audio header decoder.
// Depends on mafh_pkg, mafh_front, mafh_queue and mafh_back.
//
// Usage:
//   Input: drive i_header_word and raise start; the word is taken at a
//   rising edge where start is high and busy is low. One header may be
//   taken every cycle.
//   Output: each header yields one result, shown for exactly one cycle with
//   o_valid high, in the order the headers were taken. Results cannot be
//   held off by the receiver.
//   Pipeline: a header passes the front register, queue, dividend multiply,
//   reciprocal multiply and output register in that order.
//   Throughput: one header per cycle while busy is low, set by the two
//   pipelined multipliers that replace the divide by the sample rate.
//   busy rises only when the front register holds a header and the
//   two-entry queue is full; with the back draining every cycle this does
//   not happen in normal use.
//   Reset (i_rst_n low, synchronous) empties the front register, queue and
//   back pipeline; headers in flight are dropped and no result follows.
module mpeg_audio_frame_header_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [31:0]                  i_header_word,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [1:0]                   o_version_code,
    output logic [1:0]                   o_layer_number,
    output logic [1:0]                   o_channel_count,
    output logic [mafh_pkg::HZ_W-1:0]    o_sample_rate_hz,
    output logic [mafh_pkg::KBPS_W-1:0]  o_bit_rate_kbps,
    output logic                         o_padding_bit,
    output logic [mafh_pkg::BYTES_W-1:0] o_frame_bytes
);
    import mafh_pkg::*;

    t_xfer w_push;
    t_xfer w_head;
    logic  w_full;
    logic  w_pop;

    // classify
    mafh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_header_word (i_header_word),
        .i_full        (w_full),
        .busy          (busy),
        .o_push        (w_push)
    );

    // decouple
    mafh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // frame length datapath
    mafh_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_version_code   (o_version_code),
        .o_layer_number   (o_layer_number),
        .o_channel_count  (o_channel_count),
        .o_sample_rate_hz (o_sample_rate_hz),
        .o_bit_rate_kbps  (o_bit_rate_kbps),
        .o_padding_bit    (o_padding_bit),
        .o_frame_bytes    (o_frame_bytes)
    );

endmodule

/* tb/tb_mpeg_audio_frame_header_decode.sv */
// tb_mpeg_audio_frame_header_decode: self-checking testbench for the MPEG audio frame header
// decoder; directed headers are scored against spelled-out results or an in-bench decoder,
// random ones against the in-bench decoder. Depends on mafh_pkg and mpeg_audio_frame_header_decode.
module tb_mpeg_audio_frame_header_decode;
    timeunit 1ns;
    timeprecision 1ps;

    import mafh_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_PER_PHASE = 510;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_LIGHT   = 17;
    localparam int IDLE_HEAVY   = 69;
    localparam int IDLE_NONE    = 0;

    localparam int SPF_LAYER1 = 384;
    localparam int SPF_LONG   = 1152;
    localparam int SPF_SHORT  = 576;

    // decoded view of one header, in port order
    typedef struct packed {
        t_status             status;
        logic [1:0]          version_code;
        logic [1:0]          layer_number;
        logic [1:0]          channel_count;
        logic [HZ_W-1:0]     sample_rate_hz;
        logic [KBPS_W-1:0]   bit_rate_kbps;
        logic                padding_bit;
        logic [BYTES_W-1:0]  frame_bytes;
    } t_hdr_info;

    typedef struct packed {
        logic [31:0] hdr;
        t_hdr_info   info;
    } t_hdr_expect;

    // directed row: header word, whether the result is spelled out, the result
    typedef struct packed {
        logic [31:0] hdr;
        logic        known;
        t_hdr_info   want;
    } t_dir_row;

    // bit rate rows: MPEG1 L1, L2, L3, MPEG2/2.5 L1, MPEG2/2.5 L2 and L3
    localparam logic [KBPS_W-1:0] RATE_KBPS [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // sample rate by version code and rate index
    localparam logic [HZ_W-1:0] RATE_HZ [0:3][0:3] = '{
        '{16'd11025, 16'd12000, 16'd8000, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    // header, known, status, version, layer, channels, hz, kbps, pad, bytes
    localparam int N_DIRECTED = 21;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // all zero and all one words
        {32'h0000_0000, 1'b1, ST_NO_SYNC, 2'd0, 2'd0, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        {32'hFFFF_FFFF, 1'b1, ST_BAD_BITRATE, 2'd3, 2'd1, 2'd1, 16'd0, 9'd0, 1'b1, 11'd0},
        // sync broken in the second and in the first byte
        {32'hFFDF_FFFF, 1'b1, ST_NO_SYNC, 2'd3, 2'd1, 2'd1, 16'd0, 9'd0, 1'b1, 11'd0},
        {32'hFEFF_FFFF, 1'b1, ST_NO_SYNC, 2'd3, 2'd1, 2'd1, 16'd0, 9'd0, 1'b1, 11'd0},
        // reserved version beats reserved layer
        {32'hFFE8_0000, 1'b1, ST_RSV_VERSION, 2'd1, 2'd0, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        // reserved layer beats bad bit rate
        {32'hFFF9_F00C, 1'b1, ST_RSV_LAYER, 2'd3, 2'd0, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        // bit rate index 15 and free format, both beat the reserved rate
        {32'hFFFB_FC40, 1'b1, ST_BAD_BITRATE, 2'd3, 2'd3, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        {32'hFFFB_0C80, 1'b1, ST_BAD_BITRATE, 2'd3, 2'd3, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        // reserved rate index
        {32'hFFFB_9C00, 1'b1, ST_BAD_RATE, 2'd3, 2'd3, 2'd2, 16'd0, 9'd0, 1'b0, 11'd0},
        {32'hFFE2_1F3F, 1'b1, ST_BAD_RATE, 2'd0, 2'd3, 2'd2, 16'd0, 9'd0, 1'b1, 11'd0},
        // layer one padding adds a four byte slot
        {32'hFFFF_EA00, 1'b1, ST_OK, 2'd3, 2'd1, 2'd2, 16'd32000, 9'd448, 1'b1, 11'd676},
        // oversized MPEG2.5 layer two frame saturates
        {32'hFFE5_E800, 1'b1, ST_OK, 2'd0, 2'd2, 2'd2, 16'd8000, 9'd160, 1'b0, 11'd2047},
        // common MPEG1 layer three frame, mono
        {32'hFFFB_92C0, 1'b1, ST_OK, 2'd3, 2'd3, 2'd1, 16'd44100, 9'd128, 1'b1, 11'd418},
        // MPEG2.5 layer three frame at the lowest bit rate and 8000 Hz
        {32'hFFE3_1800, 1'b1, ST_OK, 2'd0, 2'd3, 2'd2, 16'd8000, 9'd8, 1'b0, 11'd72},
        // remaining version and layer pairs
        {32'hFFF6_1240, 1'b0, 46'd0},
        {32'hFFE7_E6C0, 1'b0, 46'd0},
        {32'hFFF5_EA80, 1'b0, 46'd0},
        {32'hFFFD_E400, 1'b0, 46'd0},
        {32'hFFF3_5600, 1'b0, 46'd0},
        {32'hFFFA_A501, 1'b0, 46'd0},
        {32'hFFFC_D4FF, 1'b0, 46'd0}
    };

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          i_header_word = '0;
    logic                 o_valid;
    logic [2:0]           o_status;
    logic [1:0]           o_version_code;
    logic [1:0]           o_layer_number;
    logic [1:0]           o_channel_count;
    logic [HZ_W-1:0]      o_sample_rate_hz;
    logic [KBPS_W-1:0]    o_bit_rate_kbps;
    logic                 o_padding_bit;
    logic [BYTES_W-1:0]   o_frame_bytes;

    t_hdr_expect pending_decodes [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          sender_idle_pct = IDLE_LIGHT;

    mpeg_audio_frame_header_decode DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_header_word    (i_header_word),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_version_code   (o_version_code),
        .o_layer_number   (o_layer_number),
        .o_channel_count  (o_channel_count),
        .o_sample_rate_hz (o_sample_rate_hz),
        .o_bit_rate_kbps  (o_bit_rate_kbps),
        .o_padding_bit    (o_padding_bit),
        .o_frame_bytes    (o_frame_bytes)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // decode one header word the way the block should
    function automatic t_hdr_info decode_header(input logic [31:0] w);
        t_hdr_info       r;
        logic [1:0]      lay_bits;
        logic [3:0]      br_idx;
        logic [1:0]      sr_idx;
        int unsigned     row;
        int unsigned     spf;
        longint unsigned frame_len;
        r = '0;
        r.version_code = w[20:19];
        lay_bits = w[18:17];
        r.layer_number = (lay_bits == 2'd0) ? LAYER_NONE : 2'(4 - int'(lay_bits));
        br_idx = w[15:12];
        sr_idx = w[11:10];
        r.padding_bit = w[9];
        r.channel_count = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;

        // first failing check wins
        if (w[31:24] != SYNC_BYTE || (w[23:16] & SYNC_HIGH) != SYNC_HIGH)
            r.status = ST_NO_SYNC;
        else if (r.version_code == VER_RESERVED)
            r.status = ST_RSV_VERSION;
        else if (r.layer_number == LAYER_NONE)
            r.status = ST_RSV_LAYER;
        else if (br_idx == BR_FREE || br_idx == BR_BAD)
            r.status = ST_BAD_BITRATE;
        else if (sr_idx == SR_RESERVED)
            r.status = ST_BAD_RATE;
        else begin
            r.status = ST_OK;
            // MPEG2 and 2.5 share the low-rate rows
            if (r.version_code == VER_MPEG1)
                row = r.layer_number - 1;
            else
                row = (r.layer_number == LAYER_ONE) ? 3 : 4;
            r.bit_rate_kbps = RATE_KBPS[row][br_idx];
            r.sample_rate_hz = RATE_HZ[r.version_code][sr_idx];
            if (r.layer_number == LAYER_ONE)
                spf = SPF_LAYER1;
            else if (r.layer_number == LAYER_TWO || r.version_code == VER_MPEG1)
                spf = SPF_LONG;
            else
                spf = SPF_SHORT;
            frame_len = 64'(spf) * 64'(r.bit_rate_kbps) * 64'(KBIT) / 64'd8;
            frame_len = frame_len / 64'(r.sample_rate_hz);
            frame_len += (r.layer_number == LAYER_ONE) ? 64'(4 * r.padding_bit)
                                                      : 64'(r.padding_bit);
            r.frame_bytes = (frame_len > 64'(FRAME_MAX)) ? FRAME_MAX : BYTES_W'(frame_len);
        end
        return r;
    endfunction

    // mostly well-formed frames, some with one broken sync bit, some with sync and random fields, some noise
    function automatic logic [31:0] random_header();
        logic [31:0] w;
        logic [1:0]  ver;
        int unsigned pick;
        int unsigned bit_pos;
        w = $urandom();
        pick = $urandom_range(99);
        if (pick < 80) begin
            w[31:21] = '1;
            ver = 2'($urandom_range(2));
            w[20:19] = (ver == VER_RESERVED) ? VER_MPEG1 : ver;
            w[18:17] = 2'($urandom_range(3, 1));
            w[15:12] = 4'($urandom_range(14, 1));
            w[11:10] = 2'($urandom_range(2));
            if (pick >= 75) begin
                bit_pos = $urandom_range(31, 21);
                w[bit_pos] = ~w[bit_pos];
            end
        end else if (pick < 90) begin
            w[31:21] = '1;
        end
        return w;
    endfunction

    // one clock: note an accepted transaction, score any result
    task automatic tick(input t_hdr_expect offered, output bit taken);
        t_hdr_info   got;
        t_hdr_expect want;
        @(posedge i_clk);
        taken = start && !busy;
        if (taken)
            pending_decodes.push_back(offered);
        if (o_valid !== 1'b0) begin
            got = {o_status, o_version_code, o_layer_number, o_channel_count,
                   o_sample_rate_hz, o_bit_rate_kbps, o_padding_bit, o_frame_bytes};
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status=%0d bytes=%0d",
                             got.status, got.frame_bytes);
            end else begin
                want = pending_decodes.pop_front();
                if (got !== want.info) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch for header %h:", want.hdr);
                        $display("  want st=%0d ver=%0d lay=%0d ch=%0d hz=%0d kbps=%0d pad=%0d bytes=%0d",
                                 want.info.status, want.info.version_code,
                                 want.info.layer_number, want.info.channel_count,
                                 want.info.sample_rate_hz, want.info.bit_rate_kbps,
                                 want.info.padding_bit, want.info.frame_bytes);
                        $display("  got  st=%0d ver=%0d lay=%0d ch=%0d hz=%0d kbps=%0d pad=%0d bytes=%0d",
                                 got.status, got.version_code, got.layer_number,
                                 got.channel_count, got.sample_rate_hz,
                                 got.bit_rate_kbps, got.padding_bit, got.frame_bytes);
                    end
                end
            end
        end
        if (taken || o_valid === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
    endtask

    // offer one header until taken, idling at random
    task automatic send_header(input t_hdr_expect item);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
                i_header_word <= $urandom();
            end else begin
                start <= 1'b1;
                i_header_word <= item.hdr;
            end
            tick(item, taken);
        end
    endtask

    // stimulus and end of run
    initial begin : stimulus
        t_hdr_expect item;
        bit          taken;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            item.hdr = DIRECTED[i].hdr;
            item.info = DIRECTED[i].known ? DIRECTED[i].want : decode_header(DIRECTED[i].hdr);
            send_header(item);
        end

        // random phases, each after the pipeline has emptied
        for (int phase = 0; phase < 3; phase++) begin
            while (pending_decodes.size() != 0) begin
                start <= 1'b0;
                tick('0, taken);
            end
            sender_idle_pct = (phase == 0) ? IDLE_LIGHT : (phase == 1) ? IDLE_HEAVY : IDLE_NONE;
            repeat (RANDOM_PER_PHASE) begin
                item.hdr = random_header();
                item.info = decode_header(item.hdr);
                send_header(item);
            end
        end

        // wait out the last results, then look for strays
        do begin
            start <= 1'b0;
            tick('0, taken);
        end while (pending_decodes.size() != 0);
        repeat (DRAIN_CYCLES) tick('0, taken);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog on cycles with no transaction and no result
    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
design/mafh_pkg.sv
design/mafh_front.sv
design/mafh_queue.sv
design/mafh_back.sv
design/mpeg_audio_frame_header_decode.sv
tb/tb_mpeg_audio_frame_header_decode.sv
